@@ rtl/core/cksa_pkg.sv @@
// Shared types and constants of the combination key seat assigner.
`default_nettype none

package cksa_pkg;

  // Configuration port layout and register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CFG_SERVER_COUNT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD    = 8'd1;

  // Register values after reset.
  localparam logic [4:0] ServerCountReset = 5'd5;
  localparam logic [4:0] ThresholdReset   = 5'd3;

  // Field widths of a result.
  localparam int unsigned RowW    = 5;
  localparam int unsigned ColW    = 20;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned OutDataW = 64;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_CFG   = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0] server_count;
    logic [4:0] threshold;
    logic       restart;
  } cfg_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            bad_cfg;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/cksa_front.sv @@
// Front part: configuration registers, key acceptance and classification.
`default_nettype none

module cksa_front #(
  parameter int unsigned MAX_SERVERS   = 24,
  parameter int unsigned MAX_THRESHOLD = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [cksa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [cksa_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire [cksa_pkg::KeyW-1:0]    s_axis_tdata_i,
  input  wire                         queue_full_i,
  output logic                        push_o,
  output cksa_pkg::item_t             item_o,
  output cksa_pkg::cfg_t              cfg_o
);
  import cksa_pkg::*;

  logic [4:0] server_count_q, server_count_d;
  logic [4:0] threshold_q, threshold_d;
  logic       cfg_write;
  logic       bad_cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_comb begin
    server_count_d = server_count_q;
    threshold_d    = threshold_q;
    if (cfg_write && cfg_index_i == CFG_SERVER_COUNT) begin
      server_count_d = cfg_data_i;
    end
    if (cfg_write && cfg_index_i == CFG_THRESHOLD) begin
      threshold_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= ServerCountReset;
      threshold_q    <= ThresholdReset;
    end else begin
      server_count_q <= server_count_d;
      threshold_q    <= threshold_d;
    end
  end

  // A setting the enumeration cannot serve marks the key for a bad-config result.
  assign bad_cfg = (threshold_q == 5'd0) ||
                   (threshold_q > server_count_q) ||
                   ({1'b0, threshold_q} > 6'(MAX_THRESHOLD)) ||
                   ({1'b0, server_count_q} > 6'(MAX_SERVERS));

  assign s_axis_tready_o = ~queue_full_i;
  assign push_o          = s_axis_tvalid_i & s_axis_tready_o;
  assign item_o.key      = s_axis_tdata_i;
  assign item_o.bad_cfg  = bad_cfg;

  assign cfg_o.server_count = server_count_q;
  assign cfg_o.threshold    = threshold_q;
  assign cfg_o.restart      = cfg_write &&
                              (cfg_index_i == CFG_SERVER_COUNT ||
                               cfg_index_i == CFG_THRESHOLD);

endmodule

`default_nettype wire

@@ rtl/core/cksa_queue.sv @@
// Short request queue between the front and the back.
`default_nettype none

module cksa_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  cksa_pkg::item_t item_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output cksa_pkg::item_t item_o
);
  import cksa_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cksa_back.sv @@
// Back part: combination state, seat counters and result generation.
`default_nettype none

module cksa_back #(
  parameter int unsigned MAX_SERVERS   = 24,
  parameter int unsigned MAX_THRESHOLD = 16,
  parameter int unsigned SEAT_BITS     = 20
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cksa_pkg::cfg_t               cfg_i,
  input  wire                          item_valid_i,
  input  cksa_pkg::item_t              item_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [cksa_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import cksa_pkg::*;

  localparam int unsigned IdxW  = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1;
  localparam int unsigned SlotW = $clog2(MAX_SERVERS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic                  exhausted_q;
  logic [4:0]            comb_q [MAX_THRESHOLD];
  logic [4:0]            comb_d [MAX_THRESHOLD];
  logic [SEAT_BITS-1:0]  seat_q [MAX_SERVERS];

  logic                  out_valid_q;
  logic [RowW-1:0]       out_row_q, out_row_d;
  logic [ColW-1:0]       out_col_q, out_col_d;
  logic [KeyW-1:0]       out_key_q, out_key_d;
  status_e               out_status_q, out_status_d;
  logic                  out_last_q, out_last_d;

  logic                  out_free, load, seat_take, advance, last_idx;
  logic [4:0]            cur_row;
  logic [SlotW-1:0]      cur_slot;
  logic [MAX_THRESHOLD-1:0] can_inc;
  logic                  found;
  logic [IdxW-1:0]       pivot;
  logic [4:0]            base;

  assign out_free = ~out_valid_q | m_axis_tready_i;
  assign cur_row  = comb_q[idx_q];
  assign cur_slot = cur_row[SlotW-1:0];
  assign last_idx = ((6'(idx_q) + 6'd1) == {1'b0, cfg_i.threshold});

  // Successor: the rightmost entry below its ceiling steps up, later entries follow it.
  always_comb begin
    found = 1'b0;
    pivot = '0;
    for (int p = 0; p < MAX_THRESHOLD; p++) begin
      can_inc[p] = (7'(p) < 7'(cfg_i.threshold)) &&
                   (7'(comb_q[p]) <
                    (7'(cfg_i.server_count) - 7'(cfg_i.threshold) + 7'(p)));
      if (can_inc[p]) begin
        found = 1'b1;
        pivot = IdxW'(p);
      end
    end
    base = comb_q[pivot];
    for (int j = 0; j < MAX_THRESHOLD; j++) begin
      comb_d[j] = comb_q[j];
      if (found && 7'(j) >= 7'(pivot) && 7'(j) < 7'(cfg_i.threshold)) begin
        comb_d[j] = 5'(7'(base) + 7'(j) - 7'(pivot) + 7'd1);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    key_d        = key_q;
    pop_o        = 1'b0;
    load         = 1'b0;
    seat_take    = 1'b0;
    advance      = 1'b0;
    out_row_d    = '0;
    out_col_d    = '0;
    out_key_d    = '0;
    out_status_d = STAT_OK;
    out_last_d   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && out_free) begin
          pop_o = 1'b1;
          if (item_i.bad_cfg) begin
            load         = 1'b1;
            out_status_d = STAT_BAD_CFG;
          end else if (exhausted_q) begin
            load         = 1'b1;
            out_status_d = STAT_EXHAUSTED;
          end else begin
            key_d   = item_i.key;
            idx_d   = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          seat_take  = 1'b1;
          out_row_d  = cur_row;
          out_col_d  = ColW'(seat_q[cur_slot]);
          out_key_d  = key_q;
          out_last_d = last_idx;
          if (last_idx) begin
            advance = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      exhausted_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_THRESHOLD; i++) begin
        comb_q[i] <= 5'(i);
      end
      for (int i = 0; i < MAX_SERVERS; i++) begin
        seat_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.restart) begin
        exhausted_q <= 1'b0;
        for (int i = 0; i < MAX_THRESHOLD; i++) begin
          comb_q[i] <= 5'(i);
        end
        for (int i = 0; i < MAX_SERVERS; i++) begin
          seat_q[i] <= '0;
        end
      end else begin
        if (advance) begin
          comb_q <= comb_d;
          if (!found) begin
            exhausted_q <= 1'b1;
          end
        end
        if (seat_take) begin
          seat_q[cur_slot] <= seat_q[cur_slot] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load) begin
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      out_key_q    <= out_key_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_key_q, out_col_q, out_row_q});
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/combination_key_seat_assigner.sv @@
// Top level of the combination key seat assigner.
// Each key request on the slave stream is given to the next threshold-of-
// server_count server combination in lexicographic order. For a usable
// configuration it yields one write per member server, in increasing server
// order, on the master stream: row, that server's next free seat and the key,
// with tlast on the final write. A bad configuration or a used-up enumeration
// yields one status result with tlast set instead.
// The configuration channel writes server_count (index 0) or threshold
// (index 1); either write restarts the enumeration and clears all seat
// counters. It is always ready and is meant to be used while the block idles.
// A key passes a two-entry queue; the back part then takes it in its idle
// state and emits its writes one by one from the emit state into the output
// register, while a status result is loaded straight from the idle state.
// No new key is taken until the last write of the current key is loaded.
// Reset loads server_count 5 and threshold 3, the first combination and zero
// seats. A stalled master stream holds its result; the queue keeps taking
// keys until it is full.
`default_nettype none

module combination_key_seat_assigner #(
  parameter int unsigned MAX_SERVERS   = 24,
  parameter int unsigned MAX_THRESHOLD = 16,
  parameter int unsigned SEAT_BITS     = 20
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [cksa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [cksa_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: key_id[31:0]
  input  wire [cksa_pkg::KeyW-1:0]     s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // tdata: server_row[4:0], seat_column[24:5], key_value[56:25], zero fill
  output logic [cksa_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import cksa_pkg::*;

  cfg_t  cfg;
  item_t push_item, head_item;
  logic  push, pop, queue_full, queue_valid;

  cksa_front #(
    .MAX_SERVERS  (MAX_SERVERS),
    .MAX_THRESHOLD(MAX_THRESHOLD)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .item_o         (push_item),
    .cfg_o          (cfg)
  );

  cksa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .item_o (head_item)
  );

  cksa_back #(
    .MAX_SERVERS  (MAX_SERVERS),
    .MAX_THRESHOLD(MAX_THRESHOLD),
    .SEAT_BITS    (SEAT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .item_valid_i   (queue_valid),
    .item_i         (head_item),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking stream testbench for the combination key seat assigner.
`timescale 1ns / 100ps

module tb;
  import cksa_pkg::*;

  localparam int MAX_SERVERS    = 24;
  localparam int MAX_THRESHOLD  = 16;
  localparam int SEAT_BITS      = 20;
  localparam int KEY_TARGET     = 310;
  localparam int SETTLE         = 6;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP      = 40;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LOW  = CFG_THRESHOLD + 1'b1;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HIGH = '1;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  typedef struct packed {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [KeyW-1:0]     key;
  } req_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [KeyW-1:0] key;
    status_e         st;
    logic            last;
  } seat_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [KeyW-1:0]       s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  combination_key_seat_assigner u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [4:0]           srv_count;
  logic [4:0]           share_count;
  logic [4:0]           combo [MAX_THRESHOLD];
  logic [SEAT_BITS-1:0] seat_next [MAX_SERVERS];
  bit                   used_up;

  req_t        pending_reqs [$];
  seat_write_t expected_writes [$];

  int  err_count = 0;
  int  keys_in = 0;
  int  writes_out = 0;
  int  cfg_writes = 0;
  int  exhausted_seen = 0;
  int  bad_cfg_seen = 0;
  int  quiet = 0;
  bit  key_taken = 0;
  bit  cfg_taken = 0;
  bit  hold_rx = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic restart_enum();
    int i;
    for (i = 0; i < MAX_THRESHOLD; i++) combo[i] = i[4:0];
    for (i = 0; i < MAX_SERVERS; i++) seat_next[i] = '0;
    used_up = 0;
  endtask

  task automatic load_register(input logic [CfgIdxW-1:0] idx,
                               input logic [CfgDataW-1:0] data);
    if (idx == CFG_SERVER_COUNT) srv_count = data;
    else if (idx == CFG_THRESHOLD) share_count = data;
    else return;
    restart_enum();
  endtask

  // Hands one key to the current combination and steps to the next one, or predicts a status result.
  task automatic assign_key(input logic [KeyW-1:0] key);
    int n, t, i, p, j;
    bit stepped;
    seat_write_t w;
    n = int'(srv_count);
    t = int'(share_count);
    if (t == 0 || t > n || t > MAX_THRESHOLD || n > MAX_SERVERS) begin
      w = '{row: '0, col: '0, key: '0, st: STAT_BAD_CFG, last: 1'b1};
      expected_writes.push_back(w);
    end else if (used_up) begin
      w = '{row: '0, col: '0, key: '0, st: STAT_EXHAUSTED, last: 1'b1};
      expected_writes.push_back(w);
    end else begin
      for (i = 0; i < t; i++) begin
        w.row = combo[i];
        w.col = '0;
        if (combo[i] < MAX_SERVERS) begin
          w.col = seat_next[combo[i]];
          seat_next[combo[i]] = seat_next[combo[i]] + 1'b1;
        end
        w.key = key;
        w.st = STAT_OK;
        w.last = (i == t - 1);
        expected_writes.push_back(w);
      end
      stepped = 0;
      for (p = t - 1; p >= 0 && !stepped; p--) begin
        if (int'(combo[p]) < n - t + p) begin
          combo[p] = combo[p] + 1'b1;
          for (j = p + 1; j < t; j++) combo[j] = combo[j - 1] + 1'b1;
          stepped = 1;
        end
      end
      if (!stepped) used_up = 1;
    end
  endtask

  task automatic push_key(input logic [KeyW-1:0] key);
    pending_reqs.push_back(req_t'{is_cfg: 1'b0, idx: '0, data: '0, key: key});
  endtask

  task automatic push_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    pending_reqs.push_back(req_t'{is_cfg: 1'b1, idx: idx, data: data, key: '0});
  endtask

  // Number of combinations, saturated so that large sets stay cheap to count.
  function automatic int combos_capped(input int n, input int t);
    longint r;
    int i, k;
    r = 1;
    k = (t < n - t) ? t : n - t;
    for (i = 0; i < k; i++) begin
      r = r * (n - i) / (i + 1);
      if (r > 1000) return 1000;
    end
    return int'(r);
  endfunction

  // Driver: one request at a time from the pending queue.
  req_t cur;
  bit   cur_busy = 0;
  int   burst_left = 8;
  int   gap_left = 0;

  always @(negedge clk_i) begin : drive
    bit next_tvalid, next_cvalid, still_offered;
    if (rst_ni) begin
      still_offered = s_axis_tvalid_i && !key_taken;
      if (key_taken || cfg_taken) cur_busy = 0;
      if (key_taken) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!cur_busy && pending_reqs.size() != 0) begin
        cur = pending_reqs.pop_front();
        cur_busy = 1;
      end
      next_tvalid = 0;
      next_cvalid = 0;
      if (cur_busy && cur.is_cfg) begin
        // Registers change only once every write has come out and the block is quiet.
        next_cvalid = (expected_writes.size() == 0 && quiet >= SETTLE);
        cfg_index_i <= cur.idx;
        cfg_data_i <= cur.data;
      end else if (cur_busy) begin
        if (still_offered) next_tvalid = 1;
        else if (gap_left > 0) gap_left--;
        else next_tvalid = 1;
        s_axis_tdata_i <= cur.key;
      end
      s_axis_tvalid_i <= next_tvalid;
      cfg_valid_i <= next_cvalid;
    end
  end

  // Receiver readiness: changing stall patterns, plus one long hold-off.
  rx_mode_e rx_mode = RX_FLOW;
  int       rx_cnt = 0;
  int       rx_len = 30;

  always @(negedge clk_i) begin : sink
    bit ready;
    rx_cnt++;
    if (rx_cnt >= rx_len) begin
      rx_cnt = 0;
      rx_len = $urandom_range(10, 80);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_FLOW:     ready = 1;
      RX_COIN:     ready = ($urandom_range(0, 1) == 1);
      RX_PERIODIC: ready = (rx_cnt % 4) != 3;
      default:     ready = ($urandom_range(0, 3) == 0);
    endcase
    m_axis_tready_i <= ready && !hold_rx && rst_ni;
  end

  // The hold-off starts inside a run of keys so that the sender keeps offering.
  initial begin : rx_holdoff
    wait (keys_in >= 120 && cur_busy && !cur.is_cfg && pending_reqs.size() >= 4 &&
          !pending_reqs[0].is_cfg && !pending_reqs[1].is_cfg && !pending_reqs[2].is_cfg);
    hold_rx = 1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 0;
  end

  // Monitor: predicts on every accepted request and checks every accepted write.
  always @(posedge clk_i) begin : watch
    seat_write_t w;
    key_taken = 0;
    cfg_taken = 0;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        quiet = 0;
        writes_out++;
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected write", m_axis_tdata_o, '0);
        end else begin
          w = expected_writes.pop_front();
          if (w.st == STAT_EXHAUSTED) exhausted_seen++;
          if (w.st == STAT_BAD_CFG) bad_cfg_seen++;
          if (m_axis_tdata_o[RowW-1:0] !== w.row)
            report_mismatch("server_row", 64'(m_axis_tdata_o[RowW-1:0]), 64'(w.row));
          if (m_axis_tdata_o[RowW +: ColW] !== w.col)
            report_mismatch("seat_column", 64'(m_axis_tdata_o[RowW +: ColW]), 64'(w.col));
          if (m_axis_tdata_o[RowW+ColW +: KeyW] !== w.key)
            report_mismatch("key_value", 64'(m_axis_tdata_o[RowW+ColW +: KeyW]),
                            64'(w.key));
          if (m_axis_tuser_o !== w.st)
            report_mismatch("status", 64'(m_axis_tuser_o), 64'(w.st));
          if (m_axis_tlast_o !== w.last)
            report_mismatch("last_write", 64'(m_axis_tlast_o), 64'(w.last));
        end
      end else begin
        quiet++;
      end
      cfg_taken = cfg_valid_i && cfg_ready_o;
      key_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (cfg_taken) begin
        load_register(cfg_index_i, cfg_data_i);
        cfg_writes++;
      end
      if (key_taken) begin
        assign_key(s_axis_tdata_i);
        keys_in++;
      end
    end
  end

  // Watchdog on cycles without any accepted request or write.
  int idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (cfg_valid_i && cfg_ready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] timeout with %0d writes outstanding", $realtime,
                 expected_writes.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int planned, i, n, t, nkeys, combos;
    srv_count = ServerCountReset;
    share_count = ThresholdReset;
    restart_enum();

    // Reset setting of five servers, three per key: ten combinations, then used up.
    push_key('0);
    push_key('1);
    push_key(32'hAAAA_AAAA);
    push_key(32'h5555_5555);
    for (i = 0; i < 6; i++) push_key($urandom);
    push_key($urandom);
    // Writes to unused indexes must not restart the enumeration.
    push_cfg(CFG_SPARE_LOW, 5'd7);
    push_cfg(CFG_SPARE_HIGH, '1);
    push_key($urandom);
    // Single server, single share.
    push_cfg(CFG_SERVER_COUNT, 5'd1);
    push_cfg(CFG_THRESHOLD, 5'd1);
    push_key(32'h8000_0000);
    push_key(32'h7FFF_FFFF);
    // Zero threshold.
    push_cfg(CFG_THRESHOLD, '0);
    push_key($urandom);
    // Widest setting.
    push_cfg(CFG_SERVER_COUNT, CfgDataW'(MAX_SERVERS));
    push_cfg(CFG_THRESHOLD, CfgDataW'(MAX_THRESHOLD));
    push_key($urandom);
    push_key($urandom);
    // Threshold beyond its limit, then server count beyond its limit.
    push_cfg(CFG_THRESHOLD, CfgDataW'(MAX_THRESHOLD + 1));
    push_key($urandom);
    push_cfg(CFG_THRESHOLD, '1);
    push_key($urandom);
    push_cfg(CFG_THRESHOLD, 5'd2);
    push_cfg(CFG_SERVER_COUNT, '1);
    push_key($urandom);
    planned = 20;

    while (planned < KEY_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: begin n = $urandom_range(1, MAX_SERVERS); t = 0; end
          1: begin n = $urandom_range(1, MAX_SERVERS - 1); t = $urandom_range(n + 1, 31); end
          2: begin n = $urandom_range(MAX_SERVERS + 1, 31); t = $urandom_range(1, 31); end
          default: begin n = MAX_SERVERS; t = $urandom_range(MAX_THRESHOLD + 1, 31); end
        endcase
        nkeys = $urandom_range(2, 4);
      end else begin
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : $urandom_range(1, MAX_SERVERS);
        t = (n < MAX_THRESHOLD) ? n : MAX_THRESHOLD;
        if ($urandom_range(0, 3) != 0 && t > 4) t = 4;
        t = $urandom_range(1, t);
        combos = combos_capped(n, t);
        // Small sets are run to the end so that the used-up case comes up often.
        if (combos <= 30) nkeys = combos + $urandom_range(0, 3);
        else nkeys = $urandom_range(6, 24);
      end
      if ($urandom_range(0, 5) == 0)
        push_cfg(CfgIdxW'($urandom_range(CFG_SPARE_LOW, CFG_SPARE_HIGH)),
                 CfgDataW'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        push_cfg(CFG_SERVER_COUNT, CfgDataW'(n));
        push_cfg(CFG_THRESHOLD, CfgDataW'(t));
      end else begin
        push_cfg(CFG_THRESHOLD, CfgDataW'(t));
        push_cfg(CFG_SERVER_COUNT, CfgDataW'(n));
      end
      for (i = 0; i < nkeys; i++) push_key($urandom);
      planned += nkeys;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reqs.size() == 0 && !cur_busy && expected_writes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d keys in, %0d writes checked, %0d register writes",
             keys_in, writes_out, cfg_writes);
    $display("summary: %0d used-up results, %0d bad-setting results, %0d mismatches",
             exhausted_seen, bad_cfg_seen, err_count);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
